// File: rtl/bdqs_pkg.sv
// Shared types and codes for the bounded deque with search.
`timescale 1ns / 1ps

package bdqs_pkg;

   // Fixed field widths
   localparam int OP_W     = 3;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 2;
   localparam int POS_W    = 4;
   localparam int COUNT_W  = 5;

   // Operation codes
   typedef enum logic [OP_W-1:0] {
      OP_PUSH_BACK  = 3'd0,
      OP_PUSH_FRONT = 3'd1,
      OP_POP_BACK   = 3'd2,
      OP_POP_FRONT  = 3'd3,
      OP_FIND       = 3'd4
   } op_type;

   // Result status codes
   localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_EMPTY    = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_FULL     = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_NOTFOUND = 2'd3;

   // Per-cycle shift control broadcast to every cell
   typedef struct packed {
      logic shift_up;    // take the entry of the cell nearer the front
      logic shift_down;  // take the entry of the cell nearer the back
   } cell_ctl_type;

endpackage

// File: rtl/bounded_deque_with_search.sv
// Top level of the bounded deque with search: cell chain and sequencer.
`timescale 1ns / 1ps
//
// Bounded double-ended queue of signed 32-bit values, CAPACITY entries.
// Request channel (req_valid / req_stall) carries one operation per
// transfer: push back, push front, pop back, pop front or find.
// Response channel (rsp_valid / rsp_stall) returns exactly one result per
// request: status, popped data, match position and entry count.
// Entries live in a chain of cells kept in order from the front in cell 0.
// Push back, push front, pop front and unused codes need no scan;
// the result is registered and shows on the next cycle.
// Pop back and find on a non-empty queue rotate the whole chain once past
// cell 0 in the scan state before the result is registered.
// A request is taken only when the sequencer is idle and the response
// register is empty or being drained in the same cycle; a stalled
// response holds its payload and blocks new requests.
// Reset empties the queue and clears the response valid flag; stored
// entries and the response payload are left as they are.
//
module bounded_deque_with_search
   import bdqs_pkg::*;
#(
   parameter int CAPACITY = 16
)(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [OP_W-1:0]            req_op,
   input  logic signed [DATA_W-1:0]   req_value,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic signed [DATA_W-1:0]   rsp_data,
   output logic [POS_W-1:0]           rsp_position,
   output logic [COUNT_W-1:0]         rsp_count
);

   localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam logic [CW-1:0] CNT_FULL = CW'(CAPACITY);
   localparam logic [IW-1:0] K_LAST   = IW'(CAPACITY - 1);

   typedef enum logic {
      S_IDLE,
      S_SCAN
   } state_type;

   state_type                state_ff, state_in;
   logic [IW-1:0]            k_ff, k_in;
   logic [CW-1:0]            cnt_ff, cnt_in;
   logic                     pop_scan_ff, pop_scan_in;
   logic signed [DATA_W-1:0] sval_ff, sval_in;
   logic                     found_ff, found_in;
   logic [POS_W-1:0]         fpos_ff, fpos_in;
   logic signed [DATA_W-1:0] pdata_ff, pdata_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]      rsp_status_ff, rsp_status_in;
   logic signed [DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [POS_W-1:0]         rsp_pos_ff, rsp_pos_in;
   logic [COUNT_W-1:0]       rsp_count_ff, rsp_count_in;

   cell_ctl_type             ctl;
   logic                     push_back;
   logic                     accept;
   logic                     k_live;
   logic signed [DATA_W-1:0] head;
   logic signed [DATA_W-1:0] cell_entry [CAPACITY];

   assign req_stall = (state_ff != S_IDLE) || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;
   assign head      = cell_entry[0];
   assign k_live    = (CW'(k_ff) < cnt_ff);

   // Build the cell chain; cell 0 is the front, the ring wraps for rotation
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      localparam int NXT = (i + 1) % CAPACITY;
      localparam logic [CW-1:0] MY_IDX = CW'(i);
      logic signed [DATA_W-1:0] prev_d;
      logic                     ld;

      if (i == 0) begin : g_head
         assign prev_d = req_value;
      end else begin : g_body
         assign prev_d = cell_entry[i-1];
      end

      assign ld = push_back && (cnt_ff == MY_IDX);

      bdqs_cell u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .load      (ld),
         .load_data (req_value),
         .prev_data (prev_d),
         .next_data (cell_entry[NXT]),
         .entry     (cell_entry[i])
      );
   end

   // Sequence operations and form the response
   always_comb begin
      state_in      = state_ff;
      k_in          = k_ff;
      cnt_in        = cnt_ff;
      pop_scan_in   = pop_scan_ff;
      sval_in       = sval_ff;
      found_in      = found_ff;
      fpos_in       = fpos_ff;
      pdata_in      = pdata_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_count_in  = rsp_count_ff;
      ctl           = '0;
      push_back     = 1'b0;

      // Drop the response once its transfer completes
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_status_in = STAT_OK;
               rsp_data_in   = '0;
               rsp_pos_in    = '0;
               rsp_valid_in  = 1'b1;
               unique case (req_op)
                  OP_PUSH_BACK: begin
                     if (cnt_ff >= CNT_FULL) begin
                        rsp_status_in = STAT_FULL;
                     end else begin
                        push_back = 1'b1;
                        cnt_in    = cnt_ff + 1'b1;
                     end
                  end
                  OP_PUSH_FRONT: begin
                     if (cnt_ff >= CNT_FULL) begin
                        rsp_status_in = STAT_FULL;
                     end else begin
                        ctl.shift_up = 1'b1;
                        cnt_in       = cnt_ff + 1'b1;
                     end
                  end
                  OP_POP_FRONT: begin
                     if (cnt_ff == '0) begin
                        rsp_status_in = STAT_EMPTY;
                     end else begin
                        rsp_data_in    = head;
                        ctl.shift_down = 1'b1;
                        cnt_in         = cnt_ff - 1'b1;
                     end
                  end
                  OP_POP_BACK, OP_FIND: begin
                     if (cnt_ff == '0) begin
                        rsp_status_in = STAT_EMPTY;
                     end else begin
                        // Start a full rotation past cell 0
                        rsp_valid_in = 1'b0;
                        state_in     = S_SCAN;
                        k_in         = '0;
                        sval_in      = req_value;
                        pop_scan_in  = (req_op == OP_POP_BACK);
                        found_in     = 1'b0;
                        fpos_in      = '0;
                        pdata_in     = '0;
                     end
                  end
                  default: begin
                  end
               endcase
               rsp_count_in = COUNT_W'(cnt_in);
            end
         end
         S_SCAN: begin
            // Cell 0 holds entry k this cycle; rotate toward the front
            ctl.shift_down = 1'b1;
            k_in           = k_ff + 1'b1;
            if (!pop_scan_ff && !found_ff && k_live && (head == sval_ff)) begin
               found_in = 1'b1;
               fpos_in  = POS_W'(k_ff);
            end
            if (pop_scan_ff && (CW'(k_ff) == (cnt_ff - 1'b1))) begin
               pdata_in = head;
            end
            if (k_ff == K_LAST) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
               if (pop_scan_ff) begin
                  cnt_in        = cnt_ff - 1'b1;
                  rsp_status_in = STAT_OK;
                  rsp_data_in   = pdata_in;
                  rsp_pos_in    = '0;
               end else begin
                  rsp_status_in = found_in ? STAT_OK : STAT_NOTFOUND;
                  rsp_data_in   = '0;
                  rsp_pos_in    = found_in ? fpos_in : '0;
               end
               rsp_count_in = COUNT_W'(cnt_in);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Hold state, counters and the response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      k_ff          <= k_in;
      pop_scan_ff   <= pop_scan_in;
      sval_ff       <= sval_in;
      found_ff      <= found_in;
      fpos_ff       <= fpos_in;
      pdata_ff      <= pdata_in;
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_data     = rsp_data_ff;
   assign rsp_position = rsp_pos_ff;
   assign rsp_count    = rsp_count_ff;

endmodule

// File: rtl/bdqs_cell.sv
// One storage cell of the deque chain: holds a single entry.
`timescale 1ns / 1ps

module bdqs_cell
   import bdqs_pkg::*;
(
   input  logic                     clock,
   input  cell_ctl_type             ctl,
   input  logic                     load,
   input  logic signed [DATA_W-1:0] load_data,
   input  logic signed [DATA_W-1:0] prev_data,
   input  logic signed [DATA_W-1:0] next_data,
   output logic signed [DATA_W-1:0] entry
);

   logic signed [DATA_W-1:0] entry_ff;
   logic signed [DATA_W-1:0] entry_in;

   // Select the next entry: local load wins, then shifts, else hold
   always_comb begin
      priority if (load) begin
         entry_in = load_data;
      end else if (ctl.shift_up) begin
         entry_in = prev_data;
      end else if (ctl.shift_down) begin
         entry_in = next_data;
      end else begin
         entry_in = entry_ff;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule
